// File: rtl/core/rsmf_pkg.sv
package rsmf_pkg;

    typedef struct packed {
        logic [15:0] range_raw;
        logic [31:0] rx_stamp;
        logic        sensor_online;
    } rsmf_poll_t;

    typedef struct packed {
        logic [7:0] range_min;
        logic       blocked;
        logic [1:0] held_count;
    } rsmf_result_t;

    // window control from the update stage
    typedef struct packed {
        logic       write;
        logic       restart;
        logic [7:0] sample;
    } rsmf_win_ctl_t;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_CLAMP_MIN   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLAMP_MAX   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_AT    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_AT  = 2'd3;

    localparam logic [7:0] CLAMP_MIN_RST  = 8'd5;
    localparam logic [7:0] CLAMP_MAX_RST  = 8'd20;
    localparam logic [7:0] BLOCK_AT_RST   = 8'd12;
    localparam logic [7:0] RELEASE_AT_RST = 8'd14;

endpackage

// File: rtl/core/rsmf_window.sv
module rsmf_window
    import rsmf_pkg::*;
#(
    parameter int unsigned WINDOW_DEPTH = 3
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  rsmf_win_ctl_t ctl,
    output logic          empty,
    output logic [7:0]    min_next,
    output logic [1:0]    held_count
);

    localparam int unsigned PTR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned LEVELS = $clog2(WINDOW_DEPTH);
    localparam int unsigned LEAVES = 1 << LEVELS;

    logic [7:0]       samples_reg [WINDOW_DEPTH];
    logic [CNT_W-1:0] held_reg;
    logic [CNT_W-1:0] held_eff;
    logic [CNT_W-1:0] held_next;
    logic [PTR_W-1:0] ptr_reg;
    logic [PTR_W-1:0] ptr_eff;
    logic [PTR_W-1:0] ptr_next;

    assign held_eff = ctl.restart ? '0 : held_reg;
    assign ptr_eff  = ctl.restart ? '0 : ptr_reg;
    assign empty    = (held_eff == '0);

    always_comb
    begin
        held_next = held_reg;
        ptr_next  = ptr_reg;
        if (ctl.write)
        begin
            ptr_next = (ptr_eff == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_eff + 1'b1;
            if (held_eff < CNT_W'(WINDOW_DEPTH))
            begin
                held_next = held_eff + 1'b1;
            end
            else
            begin
                held_next = held_eff;
            end
        end
    end

    assign held_count = 2'(held_next);

    // minimum over the held entries, new sample included; unused leaves read as 0xFF
    always_comb
    begin
        logic [7:0] vals [LEAVES];
        for (int i = 0; i < LEAVES; i++)
        begin
            vals[i] = 8'hFF;
            if (i < WINDOW_DEPTH)
            begin
                if (CNT_W'(i) < held_next)
                begin
                    vals[i] = (PTR_W'(i) == ptr_eff) ? ctl.sample : samples_reg[i];
                end
            end
        end
        for (int lvl = 0; lvl < LEVELS; lvl++)
        begin
            for (int i = 0; i < (LEAVES >> (lvl + 1)); i++)
            begin
                vals[i] = (vals[2*i+1] < vals[2*i]) ? vals[2*i+1] : vals[2*i];
            end
        end
        min_next = vals[0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.write)
        begin
            samples_reg[ptr_eff] <= ctl.sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            ptr_reg  <= '0;
        end
        else if (ctl.write)
        begin
            held_reg <= held_next;
            ptr_reg  <= ptr_next;
        end
    end

endmodule

// File: rtl/core/range_sensor_min_filter_hysteresis.sv
// Range sensor minimum filter with hysteresis.
// Poll channel: poll_valid / poll_stall / poll carry one sensor poll per item
// (reading, timestamp, online flag). Result channel: result_valid /
// result_stall / result carry the filtered distance, blocked flag and window
// fill for every poll, in order. An item moves on at a rising edge with valid
// high and stall low.
// An accepted poll is captured in the input register and is written to the
// result register once that register is free; result_valid is driven straight
// from the result register.
// One item per cycle is sustained while result_stall is low; window update,
// minimum and hysteresis compare all sit between input and result registers.
// When result_stall holds, the result register keeps its item, the input
// register fills and poll_stall then rises until the result is taken.
// Reset empties the window, clears the filtered value and blocked flag,
// and loads the limit registers with 5, 20, 12 and 14 cm. The user must
// write limits via cfg_we/cfg_index/cfg_data only while idle (not enforced).
module range_sensor_min_filter_hysteresis
    import rsmf_pkg::*;
#(
    parameter int unsigned WINDOW_DEPTH = 3
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   poll_valid,
    output logic                   poll_stall,
    input  rsmf_poll_t             poll,
    output logic                   result_valid,
    input  logic                   result_stall,
    output rsmf_result_t           result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [7:0]    clamp_min_reg;
    logic [7:0]    clamp_max_reg;
    logic [7:0]    block_at_reg;
    logic [7:0]    release_at_reg;

    logic          in_valid_reg;
    rsmf_poll_t    in_item_reg;
    logic          out_valid_reg;
    rsmf_result_t  out_item_reg;

    logic [31:0]   last_stamp_reg;
    logic [7:0]    filtered_reg;
    logic          was_online_reg;
    logic          blocked_reg;

    logic          out_free;
    logic          fire;
    logic          online;
    logic [7:0]    sample;
    rsmf_win_ctl_t win_ctl;
    logic          win_empty;
    logic [7:0]    win_min;
    logic [1:0]    win_held;
    logic [7:0]    filtered_next;
    logic          blocked_next;
    rsmf_result_t  out_item_next;

    assign out_free   = !out_valid_reg || !result_stall;
    assign fire       = in_valid_reg && out_free;
    assign poll_stall = in_valid_reg && !out_free;
    assign online     = in_item_reg.sensor_online;

    always_comb
    begin
        if (in_item_reg.range_raw < {8'd0, clamp_min_reg})
        begin
            sample = clamp_min_reg;
        end
        else if (in_item_reg.range_raw > {8'd0, clamp_max_reg})
        begin
            sample = clamp_max_reg;
        end
        else
        begin
            sample = in_item_reg.range_raw[7:0];
        end
    end

    assign win_ctl.restart = online && !was_online_reg;
    assign win_ctl.sample  = sample;
    assign win_ctl.write   = fire && online
                             && (win_empty || (in_item_reg.rx_stamp != last_stamp_reg));

    rsmf_window #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (win_ctl),
        .empty      (win_empty),
        .min_next   (win_min),
        .held_count (win_held)
    );

    always_comb
    begin
        filtered_next = win_ctl.write ? win_min : filtered_reg;
        if (!online)
        begin
            blocked_next = 1'b0;
        end
        else if (filtered_next <= block_at_reg)
        begin
            blocked_next = 1'b1;
        end
        else if (filtered_next >= release_at_reg)
        begin
            blocked_next = 1'b0;
        end
        else
        begin
            blocked_next = blocked_reg;
        end
        out_item_next.range_min  = filtered_next;
        out_item_next.blocked    = blocked_next;
        out_item_next.held_count = win_held;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_min_reg  <= CLAMP_MIN_RST;
            clamp_max_reg  <= CLAMP_MAX_RST;
            block_at_reg   <= BLOCK_AT_RST;
            release_at_reg <= RELEASE_AT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CLAMP_MIN:  clamp_min_reg  <= cfg_data;
                CFG_CLAMP_MAX:  clamp_max_reg  <= cfg_data;
                CFG_BLOCK_AT:   block_at_reg   <= cfg_data;
                CFG_RELEASE_AT: release_at_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_stamp_reg <= '0;
            filtered_reg   <= '0;
            was_online_reg <= 1'b0;
            blocked_reg    <= 1'b0;
        end
        else
        begin
            if (!poll_stall)
            begin
                in_valid_reg <= poll_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                was_online_reg <= online;
                blocked_reg    <= blocked_next;
                filtered_reg   <= filtered_next;
            end
            if (win_ctl.write)
            begin
                last_stamp_reg <= in_item_reg.rx_stamp;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll_valid && !poll_stall)
        begin
            in_item_reg <= poll;
        end
        if (fire)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule

// File: dv/range_sensor_min_filter_hysteresis_tb.sv
`timescale 1ns / 100ps

module range_sensor_min_filter_hysteresis_tb;
    import rsmf_pkg::*;

    localparam int unsigned WIN_DEPTH    = 3;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned HOLD_CYCLES  = 150;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned PHASES       = 8;
    localparam int unsigned PHASE_POLLS  = 205;
    localparam int unsigned MAX_PRINTED  = 40;

    logic                   clk;
    logic                   rst_n;
    logic                   poll_valid;
    logic                   poll_stall;
    rsmf_poll_t             poll;
    logic                   result_valid;
    logic                   result_stall;
    rsmf_result_t           result;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    bit                     hold_req;
    logic [31:0]            stamp_now;
    int unsigned            cycles;

    // limits per phase: clamp min, clamp max, block at, release at (last row unused)
    logic [7:0] phase_limits [PHASES][4] = '{
        '{8'd5,   8'd20,  8'd12,  8'd14},
        '{8'd0,   8'd255, 8'd0,   8'd255},
        '{8'd255, 8'd0,   8'd255, 8'd0},
        '{8'd10,  8'd40,  8'd20,  8'd20},
        '{8'd0,   8'd0,   8'd0,   8'd0},
        '{8'd255, 8'd255, 8'd255, 8'd255},
        '{8'd3,   8'd60,  8'd25,  8'd18},
        '{8'd0,   8'd0,   8'd0,   8'd0}
    };

    class min_filter_scoreboard;
        logic [7:0]   lim_min;
        logic [7:0]   lim_max;
        logic [7:0]   lim_block;
        logic [7:0]   lim_release;
        logic [7:0]   window [WIN_DEPTH];
        int unsigned  held;
        int unsigned  wr_ptr;
        logic [31:0]  last_stamp;
        logic [7:0]   filt;
        bit           was_online;
        bit           blocked;
        rsmf_result_t due_results [$];
        int unsigned  errors;

        function new();
            lim_min     = CLAMP_MIN_RST;
            lim_max     = CLAMP_MAX_RST;
            lim_block   = BLOCK_AT_RST;
            lim_release = RELEASE_AT_RST;
            held        = 0;
            wr_ptr      = 0;
            last_stamp  = '0;
            filt        = '0;
            was_online  = 1'b0;
            blocked     = 1'b0;
            errors      = 0;
        endfunction

        function void set_limit(logic [CFG_INDEX_W-1:0] idx, logic [7:0] v);
            case (idx)
                CFG_CLAMP_MIN:  lim_min     = v;
                CFG_CLAMP_MAX:  lim_max     = v;
                CFG_BLOCK_AT:   lim_block   = v;
                CFG_RELEASE_AT: lim_release = v;
                default: ;
            endcase
        endfunction

        function logic [7:0] clamp(logic [15:0] d);
            if (d < {8'd0, lim_min})
                return lim_min;
            if (d > {8'd0, lim_max})
                return lim_max;
            return d[7:0];
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction

        function void take_poll(rsmf_poll_t p);
            rsmf_result_t e;
            logic [7:0]   s;
            if (!p.sensor_online)
            begin
                was_online = 1'b0;
                blocked    = 1'b0;
            end
            else
            begin
                s = clamp(p.range_raw);
                if (!was_online)
                begin
                    held       = 0;
                    wr_ptr     = 0;
                    was_online = 1'b1;
                end
                if (held == 0 || p.rx_stamp != last_stamp)
                begin
                    window[wr_ptr] = s;
                    wr_ptr = (wr_ptr + 1) % WIN_DEPTH;
                    if (held < WIN_DEPTH)
                        held++;
                    last_stamp = p.rx_stamp;
                    filt = window[0];
                    for (int unsigned i = 1; i < held; i++)
                        if (window[i] < filt)
                            filt = window[i];
                end
                if (filt <= lim_block)
                    blocked = 1'b1;
                else if (filt >= lim_release)
                    blocked = 1'b0;
            end
            e.range_min  = filt;
            e.blocked    = blocked;
            e.held_count = 2'(held);
            due_results.push_back(e);
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED)
                $display("%0t ns: %s", $time, msg);
            errors++;
        endtask

        task match_result(rsmf_result_t r);
            rsmf_result_t e;
            if (due_results.size() == 0)
            begin
                report($sformatf("result %p with no poll outstanding", r));
                return;
            end
            e = due_results.pop_front();
            if (r.range_min !== e.range_min)
                report($sformatf("range_min %0d, want %0d", r.range_min, e.range_min));
            if (r.blocked !== e.blocked)
                report($sformatf("blocked %b, want %b", r.blocked, e.blocked));
            if (r.held_count !== e.held_count)
                report($sformatf("held_count %0d, want %0d", r.held_count, e.held_count));
        endtask

        task check_drained();
            if (due_results.size() != 0)
                report($sformatf("%0d results never arrived", due_results.size()));
        endtask
    endclass

    min_filter_scoreboard sb;

    range_sensor_min_filter_hysteresis #(
        .WINDOW_DEPTH (WIN_DEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .poll_valid   (poll_valid),
        .poll_stall   (poll_stall),
        .poll         (poll),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: random stalls, quiet stretches, and a long hold on request
    initial
    begin
        int unsigned stall_left;
        int unsigned quiet_left;
        int unsigned r;
        result_stall = 1'b0;
        stall_left   = 0;
        quiet_left   = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
                quiet_left = 0;
            end
            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                result_stall <= 1'b0;
                if (quiet_left > 0)
                    quiet_left--;
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 8)
                        quiet_left = $urandom_range(20, 80);
                    else if (r < 22)
                        stall_left = $urandom_range(1, 3);
                    else if (r < 24)
                        stall_left = $urandom_range(10, 40);
                end
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                sb.match_result(result);
        end
    end

    function automatic rsmf_poll_t make_poll(logic [15:0] d, logic [31:0] s, logic online);
        rsmf_poll_t p;
        p.range_raw     = d;
        p.rx_stamp      = s;
        p.sensor_online = online;
        return p;
    endfunction

    function automatic rsmf_poll_t random_poll();
        int unsigned r;
        logic [15:0] d;
        r = $urandom_range(0, 99);
        if (r < 55)
            d = 16'($urandom_range(0, 48));
        else if (r < 85)
            d = 16'($urandom_range(0, 300));
        else
            d = 16'($urandom_range(0, 65535));
        r = $urandom_range(0, 99);
        if (r < 78)
            stamp_now = stamp_now + 32'($urandom_range(1, 1000));
        else if (r >= 93)
            stamp_now = $urandom();
        return make_poll(d, stamp_now, $urandom_range(0, 99) >= 8);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    task automatic send_poll(rsmf_poll_t p, int unsigned gap);
        repeat (gap)
        begin
            @(negedge clk);
            poll_valid <= 1'b0;
        end
        @(negedge clk);
        poll_valid <= 1'b1;
        poll       <= p;
        do
            @(posedge clk);
        while (poll_stall);
        sb.take_poll(p);
    endtask

    task automatic stop_polls();
        @(negedge clk);
        poll_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(logic [CFG_INDEX_W-1:0] idx, logic [7:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        sb.set_limit(idx, v);
    endtask

    task automatic set_limits(logic [7:0] lo, logic [7:0] hi, logic [7:0] blk, logic [7:0] rel);
        write_limit(CFG_CLAMP_MIN, lo);
        write_limit(CFG_CLAMP_MAX, hi);
        write_limit(CFG_BLOCK_AT, blk);
        write_limit(CFG_RELEASE_AT, rel);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        rsmf_poll_t  directed [$];
        logic [7:0]  lim [4];
        rsmf_poll_t  p;
        sb           = new();
        hold_req     = 1'b0;
        stamp_now    = '0;
        rst_n        = 1'b0;
        poll_valid   = 1'b0;
        poll         = '0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_CLAMP_MIN;
        cfg_data     = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset limits: empty window, clamps, stamp repeats, hysteresis band, offline
        directed = '{
            make_poll(16'd9,     32'd0,          1'b0),
            make_poll(16'd0,     32'd0,          1'b1),
            make_poll(16'd0,     32'd0,          1'b1),
            make_poll(16'hFFFF,  32'd1,          1'b1),
            make_poll(16'd13,    32'd2,          1'b1),
            make_poll(16'd16,    32'd3,          1'b1),
            make_poll(16'd14,    32'd4,          1'b1),
            make_poll(16'd30,    32'd5,          1'b1),
            make_poll(16'd13,    32'd6,          1'b1),
            make_poll(16'd12,    32'd6,          1'b1),
            make_poll(16'd12,    32'd7,          1'b1),
            make_poll(16'h0000,  32'd8,          1'b0),
            make_poll(16'hFFFF,  32'hFFFF_FFFF,  1'b0),
            make_poll(16'd20,    32'd7,          1'b1),
            make_poll(16'd255,   32'hFFFF_FFFF,  1'b1),
            make_poll(16'd256,   32'h8000_0000,  1'b1),
            make_poll(16'h8000,  32'h5555_5555,  1'b1),
            make_poll(16'h7FFF,  32'hAAAA_AAAA,  1'b1)
        };
        foreach (directed[i])
            send_poll(directed[i], pick_gap());
        stop_polls();
        wait_drained();

        // crossed clamp limits and equal hysteresis levels
        set_limits(8'd30, 8'd10, 8'd20, 8'd20);
        directed = '{
            make_poll(16'd5,  32'd100, 1'b1),
            make_poll(16'd20, 32'd101, 1'b1),
            make_poll(16'd40, 32'd102, 1'b1),
            make_poll(16'd30, 32'd103, 1'b1)
        };
        foreach (directed[i])
            send_poll(directed[i], pick_gap());
        stop_polls();
        wait_drained();

        for (int unsigned ph = 0; ph < PHASES; ph++)
        begin
            for (int unsigned k = 0; k < 4; k++)
                lim[k] = (ph == PHASES - 1) ? 8'($urandom_range(0, 60)) : phase_limits[ph][k];
            set_limits(lim[0], lim[1], lim[2], lim[3]);
            if (ph == 1)
                hold_req = 1'b1;
            for (int unsigned n = 0; n < PHASE_POLLS; n++)
            begin
                p = random_poll();
                send_poll(p, (n % 100 < 20) ? 0 : pick_gap());
            end
            stop_polls();
            wait_drained();
        end

        sb.check_drained();
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/rsmf_pkg.sv
rtl/core/rsmf_window.sv
rtl/core/range_sensor_min_filter_hysteresis.sv
dv/range_sensor_min_filter_hysteresis_tb.sv
